@@ hw/rtl/tpaf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpaf_pkg;

   localparam int TablePoints = 6;
   localparam int VoltW       = 8;
   localparam int DelayW      = 12;
   localparam int CountW      = 12;
   localparam int PulseW      = 8;
   localparam int LutDepth    = 1 << VoltW;

   localparam int  TBL_DELAY [TablePoints] = '{300, 1100, 1500, 1800, 2000, 2400};
   localparam int  TBL_VOLT  [TablePoints] = '{220, 200, 150, 110, 77, 20};

   localparam logic [PulseW-1:0] PULSE_RESET = 8'd10;
   localparam logic [DelayW-1:0] DELAY_MIN   = 12'd300;
   localparam logic [DelayW-1:0] DELAY_MAX   = 12'd2400;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_DELAY = 3'b010,
      PH_PULSE = 3'b100
   } phase_type;

   typedef struct packed {
      logic [VoltW-1:0] voltage;
      logic             zero_cross;
   } req_data_type;

   typedef struct packed {
      logic              busy_res;
      logic [DelayW-1:0] fire_delay;
      logic              gate;
   } rsp_data_type;

   // first curve segment holding a voltage, evaluated at elaboration only
   function automatic int segment_of(input int v);
      int seg;
      seg = TablePoints - 2;
      for (int k = TablePoints - 3; k >= 0; k--) begin
         if (v >= TBL_VOLT[k+1]) begin
            seg = k;
         end
      end
      return seg;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/triac_phase_angle_firing.sv @@
`timescale 1ns / 1ps
`default_nettype none
// triac phase-angle firing controller, one request transfer per microsecond tick.
// request channel: tdata carries the zero-cross flag and the requested voltage.
// response channel: one transfer per request, giving gate, firing delay and busy
// as they stand after that tick.
// a zero-cross is held pending; when idle it starts a countdown of the delay
// looked up from the voltage, then the gate is driven for csr_wdata ticks
// (written through csr_wen, zero acts as one).
// a response is registered: it enters the response register, or the skid register
// while the output is held. throughput: one transfer per cycle while req_tready is
// high; the lookup and next-state logic sit between the request and those registers.
// a two-entry output (response register plus skid register) lets a request be
// taken while a response waits; req_tready drops only when both are full.
// reset: synchronous, clears pending cross, phase, count and both output
// entries, and sets the pulse length to ten ticks.
// a stalled receiver simply holds the response; state advances only per
// accepted request, so timing is counted in transfers, not cycles.
module triac_phase_angle_firing (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // zero_cross, voltage[8:1], zeros
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // gate, fire_delay[12:1], busy_res[13], zeros
   input  wire         csr_wen,
   input  wire  [7:0]  csr_wdata
);

   tpaf_pkg::req_data_type             req;
   tpaf_pkg::rsp_data_type             res;
   tpaf_pkg::rsp_data_type             out_data_ff, out_data_in;
   tpaf_pkg::rsp_data_type             skid_data_ff, skid_data_in;
   logic                               out_valid_ff, out_valid_in;
   logic                               skid_valid_ff, skid_valid_in;
   tpaf_pkg::phase_type                phase_ff, phase_in;
   logic                               pending_ff, pending_in;
   logic [tpaf_pkg::CountW-1:0]        count_ff, count_in;
   logic [tpaf_pkg::PulseW-1:0]        pulse_len_ff, pulse_len_in;
   logic [tpaf_pkg::PulseW-1:0]        pulse_m1;
   logic [tpaf_pkg::DelayW-1:0]        delay;
   logic [tpaf_pkg::DelayW-1:0]        delay_lut [tpaf_pkg::LutDepth];
   logic                               pend;
   logic                               accept;

   assign req        = tpaf_pkg::req_data_type'(req_tdata[8:0]);
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff};

   // voltage to firing delay, one constant entry per voltage
   for (genvar v = 0; v < tpaf_pkg::LutDepth; v++) begin : g_lut
      localparam int SegIdx = tpaf_pkg::segment_of(v);
      localparam int Entry  =
         (v >= tpaf_pkg::TBL_VOLT[0]) ? tpaf_pkg::TBL_DELAY[0] :
         (v <= tpaf_pkg::TBL_VOLT[tpaf_pkg::TablePoints-1]) ?
            tpaf_pkg::TBL_DELAY[tpaf_pkg::TablePoints-1] :
         tpaf_pkg::TBL_DELAY[SegIdx] +
            ((tpaf_pkg::TBL_VOLT[SegIdx] - v) *
             (tpaf_pkg::TBL_DELAY[SegIdx+1] - tpaf_pkg::TBL_DELAY[SegIdx])) /
            (tpaf_pkg::TBL_VOLT[SegIdx] - tpaf_pkg::TBL_VOLT[SegIdx+1]);
      assign delay_lut[v] = tpaf_pkg::DelayW'(Entry);
   end

   assign delay    = delay_lut[req.voltage];
   assign pulse_m1 = (pulse_len_ff == '0) ? '0 : pulse_len_ff - 1'b1;
   assign pend     = pending_ff || req.zero_cross;

   assign pulse_len_in = csr_wen ? csr_wdata : pulse_len_ff;

   // tick state machine
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      if (accept) begin
         pending_in = pend;
         unique case (phase_ff)
            tpaf_pkg::PH_DELAY: begin
               if (count_ff == '0) begin
                  phase_in = tpaf_pkg::PH_PULSE;
                  count_in = {{(tpaf_pkg::CountW-tpaf_pkg::PulseW){1'b0}}, pulse_m1};
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            tpaf_pkg::PH_PULSE: begin
               if (count_ff == '0) begin
                  phase_in = tpaf_pkg::PH_IDLE;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               phase_in = tpaf_pkg::PH_IDLE;
               if (pend) begin
                  pending_in = 1'b0;
                  phase_in   = tpaf_pkg::PH_DELAY;
                  count_in   = delay - 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      res.gate       = (phase_in == tpaf_pkg::PH_PULSE);
      res.fire_delay = delay;
      res.busy_res   = (phase_in != tpaf_pkg::PH_IDLE);
   end

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tpaf_pkg::PH_IDLE;
         pending_ff    <= 1'b0;
         count_ff      <= '0;
         pulse_len_ff  <= tpaf_pkg::PULSE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pending_ff    <= pending_in;
         count_ff      <= count_in;
         pulse_len_ff  <= pulse_len_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTH
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a response in the output register");

   a_gate_implies_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_data_ff.gate || out_data_ff.busy_res))
      else $error("gate driven while not busy");

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.fire_delay >= tpaf_pkg::DELAY_MIN &&
                        out_data_ff.fire_delay <= tpaf_pkg::DELAY_MAX))
      else $error("firing delay out of range");

   a_start_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == tpaf_pkg::PH_IDLE && pend) |=>
      (!pending_ff && phase_ff == tpaf_pkg::PH_DELAY))
      else $error("pending cross not consumed on firing start");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !skid_valid_ff))
      else $error("output entries not cleared by reset");
`endif

endmodule

`default_nettype wire

@@ bench/triac_firing_checker.sv @@
`timescale 1ns / 1ps

module triac_firing_checker
   import tpaf_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [15:0] req_tdata,   // zero_cross, voltage[8:1], zeros
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,   // gate, fire_delay[12:1], busy_res[13], zeros
   input  wire         csr_wen,
   input  wire  [7:0]  csr_wdata,
   output int unsigned fail_count,
   output int unsigned pending_results,
   output int unsigned ticks_checked,
   output int unsigned pulses_predicted
);

   rsp_data_type      firing_outputs_due [$];
   logic              cross_pending;
   phase_type         phase;
   logic [CountW-1:0] ticks_left;
   logic [PulseW-1:0] pulse_len;

   function automatic logic [DelayW-1:0] interpolate(input int unsigned v_hi, v_lo, d_lo, d_hi,
                                                     input int unsigned volts);
      return DelayW'(d_lo + ((v_hi - volts) * (d_hi - d_lo)) / (v_hi - v_lo));
   endfunction

   always @(posedge clock) begin : watch
      req_data_type      tick_in;
      rsp_data_type      seen;
      rsp_data_type      due;
      logic [DelayW-1:0] delay;
      logic [PulseW-1:0] width;
      if (reset) begin
         firing_outputs_due.delete();
         cross_pending = 1'b0;
         phase         = PH_IDLE;
         ticks_left    = '0;
         pulse_len     = PULSE_RESET;
      end else begin
         if (csr_wen) begin
            pulse_len = csr_wdata;
         end
         // a response always trails its request, so compare before predicting
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[$bits(rsp_data_type)-1:0];
            ticks_checked++;
            if (firing_outputs_due.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: response transfer with nothing due: gate %0b delay %0d busy %0b",
                           $realtime, seen.gate, seen.fire_delay, seen.busy_res);
               end
               fail_count++;
            end else begin
               due = firing_outputs_due.pop_front();
               if (seen.gate !== due.gate || seen.fire_delay !== due.fire_delay ||
                   seen.busy_res !== due.busy_res) begin
                  if (fail_count < 10) begin
                     $display("%0t: tick %0d expected gate %0b delay %0d busy %0b, got %0b %0d %0b",
                              $realtime, ticks_checked, due.gate, due.fire_delay, due.busy_res,
                              seen.gate, seen.fire_delay, seen.busy_res);
                  end
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            tick_in = req_tdata[$bits(req_data_type)-1:0];
            // clamps, then the segments of the curve, first match wins
            if (tick_in.voltage >= 8'd220) begin
               delay = DELAY_MIN;
            end else if (tick_in.voltage <= 8'd20) begin
               delay = DELAY_MAX;
            end else if (tick_in.voltage >= 8'd200) begin
               delay = interpolate(220, 200, 300, 1100, tick_in.voltage);
            end else if (tick_in.voltage >= 8'd150) begin
               delay = interpolate(200, 150, 1100, 1500, tick_in.voltage);
            end else if (tick_in.voltage >= 8'd110) begin
               delay = interpolate(150, 110, 1500, 1800, tick_in.voltage);
            end else if (tick_in.voltage >= 8'd77) begin
               delay = interpolate(110, 77, 1800, 2000, tick_in.voltage);
            end else begin
               delay = interpolate(77, 20, 2000, 2400, tick_in.voltage);
            end
            width = (pulse_len == '0) ? PulseW'(1) : pulse_len;
            if (tick_in.zero_cross) begin
               cross_pending = 1'b1;
            end
            case (phase)
               PH_DELAY: begin
                  if (ticks_left == '0) begin
                     phase      = PH_PULSE;
                     ticks_left = CountW'(width) - 1'b1;
                     pulses_predicted++;
                  end else begin
                     ticks_left = ticks_left - 1'b1;
                  end
               end
               PH_PULSE: begin
                  if (ticks_left == '0) begin
                     phase = PH_IDLE;
                  end else begin
                     ticks_left = ticks_left - 1'b1;
                  end
               end
               default: begin
                  phase = PH_IDLE;
                  if (cross_pending) begin
                     cross_pending = 1'b0;
                     phase         = PH_DELAY;
                     ticks_left    = CountW'(delay) - 1'b1;
                  end
               end
            endcase
            due.gate       = (phase == PH_PULSE);
            due.fire_delay = delay;
            due.busy_res   = (phase != PH_IDLE);
            firing_outputs_due.push_back(due);
         end
      end
      pending_results = firing_outputs_due.size();
   end

endmodule

@@ bench/triac_phase_angle_firing_tb.sv @@
`timescale 1ns / 1ps

module triac_phase_angle_firing_tb;
   import tpaf_pkg::*;

   localparam int unsigned CycleLimit    = 100000;
   localparam int unsigned TicksPerPhase = 170;
   localparam int unsigned HoldOffCycles = 80;
   localparam int unsigned DirectedCount = 22;
   localparam int unsigned PhaseCount    = 5;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic [15:0] req_tdata;
   logic        rsp_tready;
   logic        csr_wen;
   logic [7:0]  csr_wdata;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned ticks_checked;
   int unsigned pulses_predicted;
   bit          calm;
   bit          hold_off_go;
   logic [7:0]  rand_len;
   logic [8:0]  directed_ticks [DirectedCount];

   triac_phase_angle_firing u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   triac_firing_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_wen          (csr_wen),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .ticks_checked    (ticks_checked),
      .pulses_predicted (pulses_predicted)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // receiver side, with one long hold-off on request
   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 14);
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_tick(input req_data_type tick);
      while (!calm && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, tick};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_pulse_len(input logic [7:0] ticks);
      csr_wdata <= ticks;
      csr_wen   <= 1'b1;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic drain();
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      req_data_type tick;
      int unsigned  ph;
      int unsigned  k;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wen     = 1'b0;
      csr_wdata   = '0;
      calm        = 1'b0;
      hold_off_go = 1'b0;
      rand_len    = 8'($urandom_range(254, 2));
      // cross on idle, crosses while busy merging, clamps, knees and their neighbours
      directed_ticks = '{
         {8'd255, 1'b1}, {8'd220, 1'b0}, {8'd221, 1'b0}, {8'd219, 1'b1},
         {8'd200, 1'b1}, {8'd201, 1'b0}, {8'd199, 1'b0}, {8'd151, 1'b0},
         {8'd150, 1'b0}, {8'd149, 1'b0}, {8'd123, 1'b0}, {8'd111, 1'b0},
         {8'd110, 1'b0}, {8'd109, 1'b0}, {8'd78, 1'b0},  {8'd77, 1'b0},
         {8'd76, 1'b0},  {8'd21, 1'b0},  {8'd20, 1'b0},  {8'd0, 1'b0},
         {8'd170, 1'b0}, {8'd85, 1'b0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < DirectedCount; k++) begin
         send_tick(req_data_type'(directed_ticks[k]));
      end

      // first phase keeps the reset pulse length
      for (ph = 0; ph < PhaseCount; ph++) begin
         if (ph != 0) begin
            req_tvalid <= 1'b0;
            drain();
            case (ph)
               1: write_pulse_len(8'd1);
               2: write_pulse_len(8'd255);
               3: write_pulse_len(8'd0);
               default: write_pulse_len(rand_len);
            endcase
         end
         calm = (ph == 2);
         if (ph == 2) begin
            hold_off_go = 1'b1;
         end
         for (k = 0; k < TicksPerPhase; k++) begin
            tick.zero_cross = ($urandom_range(99) < 12);
            tick.voltage    = $urandom_range(1) ? 8'($urandom_range(255, 220)) : 8'($urandom);
            send_tick(tick);
         end
      end
      req_tvalid <= 1'b0;
      drain();
      repeat (4) @(negedge clock);

      $display("checked %0d ticks with pulse lengths 10, 1, 255, 0 and %0d; %0d gate pulses",
               ticks_checked, rand_len, pulses_predicted);
      $display("voltages swept clamps, table knees and interpolation; receiver held off %0d cycles",
               HoldOffCycles);
      if (fail_count == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
